FILE: rtl/chs_pkg.sv
`timescale 1ns / 1ps
// Package for the chained hash set of key triples.
// Holds state and mode types, operation codes and hash constants; no dependencies.
package chs_pkg;

	localparam int HEAD_LOG2_MAX   = 11;
	localparam int HEAD_DEPTH      = 2048;
	localparam int HEAD_AW         = 11;
	localparam int SIZE_W          = 4;
	localparam int FUNC_W          = 2;
	localparam int LIVE_W          = 11;
	localparam int HASH_W          = 32;
	localparam logic [SIZE_W-1:0] RESET_SIZE_LOG2 = 4'd4;

	localparam logic [HASH_W-1:0] HASH_K_A = 32'd159403;
	localparam logic [HASH_W-1:0] HASH_K_B = 32'd389651;
	localparam logic [HASH_W-1:0] HASH_K_C = 32'd521503;

	typedef enum logic [FUNC_W-1:0] {
		FN_FIND   = 2'd0,
		FN_ADD    = 2'd1,
		FN_REMOVE = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_HASH,
		ST_HEAD,
		ST_HEADW,
		ST_WALK,
		ST_CMP,
		ST_DECIDE,
		ST_RH_RD,
		ST_RH_CHK,
		ST_REMOVE,
		ST_DONE
	} st_t;

	typedef enum logic [2:0] {
		M_INIT,
		M_CLEAR,
		M_LOOKUP,
		M_REHASH,
		M_INSERT
	} mode_t;

endpackage

FILE: rtl/chained_hash_set_triples_top.sv
`timescale 1ns / 1ps
// Top level of the chained hash set of key triples: sequencer, shared hash
// multiplier, head table and entry pool memories. Depends on chs_pkg.

// A set of key triples held as a head table of chains plus an entry pool. Each
// word on the input channel is one operation (find, add, remove, clear) and
// gives exactly one result word. The design is one small sequencer around a
// single shared 32-bit multiplier that forms the bucket hash from one product
// per key word and a last accumulate, and memories with one write and one
// read port whose read data is registered. Each operation hashes its key and
// reads the head, walks the chain entry by entry, then finishes after a hit,
// a miss or a remove; an add that inserts hashes again and links the new
// entry. A clear sweeps every head of the current table (2^size_log2 heads).
// An add that inserts while the live entries are already at 75% or more of
// the head count, below the largest table, first sweeps the doubled head
// table and then rehashes the live slots of the pool, skipping removed slots.
// After reset and after each configuration write the head table is swept over
// its 2^size_log2 heads (16 after reset), while no operation is taken. Input
// and configuration words are taken only in the idle state, and a
// configuration word has priority over a waiting input word; a finished result
// waits in the output register, and the next operation is taken as soon as
// that result has been loaded.
module chained_hash_set_triples_top #(
	parameter int MAX_ENTRIES = 1024,
	parameter int KEY_WIDTH   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [chs_pkg::SIZE_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [chs_pkg::FUNC_W-1:0]    func,
	input  logic [31:0]                   key_a,
	input  logic [31:0]                   key_b,
	input  logic [31:0]                   key_c,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic                          pool_full,
	output logic [chs_pkg::LIVE_W-1:0]    live_count
);
	import chs_pkg::*;

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int LW = $clog2(MAX_ENTRIES + 1);
	localparam int KW3 = 3 * KEY_WIDTH;
	localparam logic [LW-1:0] NIL = LW'(MAX_ENTRIES);

	// Memories
	logic [LW-1:0]  head_mem [HEAD_DEPTH];
	logic [KW3-1:0] key_mem  [MAX_ENTRIES];
	logic [LW-1:0]  link_mem [MAX_ENTRIES];
	logic           rm_mem   [MAX_ENTRIES];

	logic                head_we, key_we, link_we, rm_we;
	logic [HEAD_AW-1:0]  head_wa, head_ra;
	logic [LW-1:0]       head_wd, head_rd_q;
	logic [AW-1:0]       key_wa, key_ra, link_wa, rm_wa;
	logic [KW3-1:0]      key_wd, key_rd_q;
	logic [LW-1:0]       link_wd, link_rd_q;
	logic                rm_wd, rm_rd_q;

	// Control state
	st_t                 state_q, state_d;
	mode_t               mode_q;
	logic [SIZE_W-1:0]   size_q;
	logic [LW-1:0]       used_q, removed_q, ri_q;
	logic [HEAD_AW-1:0]  sw_q;
	logic [1:0]          hcnt_q;
	logic                out_valid_q;

	// Item and datapath registers
	func_t               func_q;
	logic [KW3-1:0]      item_q;
	logic [KEY_WIDTH-1:0] op_a_q, op_b_q, op_c_q;
	logic [HASH_W-1:0]   prod_q, acc_q;
	logic [HEAD_AW-1:0]  h_q;
	logic [LW-1:0]       cur_q, prev_q, slot_q, next_q;
	logic                found_q, full_q;
	logic                found_out_q, full_out_q;
	logic [LIVE_W-1:0]   live_out_q;

	// Derived values
	logic [HEAD_AW-1:0]  bucket, sw_last;
	logic [KEY_WIDTH-1:0] mul_op;
	logic [HASH_W-1:0]   mul_k;
	logic [31:0]         live32;
	logic                grow, cur_ok, key_hit, in_acc, cfg_acc, done_load, ri_last;

	assign bucket  = acc_q[HEAD_AW-1:0] & ~({HEAD_AW{1'b1}} << size_q);
	assign sw_last = HEAD_AW'((12'd1 << size_q) - 12'd1);
	assign live32  = 32'(used_q - removed_q);
	// Grow when live entries reach three quarters of the heads.
	assign grow    = ((live32 << 2) >= (32'd3 << size_q)) &&
	                 (size_q < SIZE_W'(HEAD_LOG2_MAX));
	assign cur_ok  = cur_q < used_q;
	assign key_hit = key_rd_q == item_q;
	assign ri_last = (LW'(ri_q + 1'b1) >= used_q);

	// Take a configuration word only when idle, ahead of any input word.
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;
	assign in_acc    = in_valid && in_ready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign done_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign out_valid  = out_valid_q;
	assign found      = found_out_q;
	assign pool_full  = full_out_q;
	assign live_count = live_out_q;

	// Shared multiplier operand select: one key word per hash cycle.
	always_comb begin
		unique case (hcnt_q)
			2'd0: begin
				mul_op = op_a_q;
				mul_k  = HASH_K_A;
			end
			2'd1: begin
				mul_op = op_b_q;
				mul_k  = HASH_K_B;
			end
			default: begin
				mul_op = op_c_q;
				mul_k  = HASH_K_C;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_SWEEP: begin
				if (sw_q == sw_last) begin
					priority case (mode_q)
						M_CLEAR:  state_d = ST_DONE;
						M_REHASH: state_d = (used_q == '0) ? ST_HASH : ST_RH_RD;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_IDLE: begin
				if (cfg_acc) begin
					state_d = ST_SWEEP;
				end else if (in_acc) begin
					state_d = (func_t'(func) == FN_CLEAR) ? ST_SWEEP : ST_HASH;
				end
			end
			ST_HASH: begin
				if (hcnt_q == 2'd3) begin
					state_d = ST_HEAD;
				end
			end
			ST_HEAD:  state_d = ST_HEADW;
			ST_HEADW: begin
				priority case (mode_q)
					M_LOOKUP: state_d = ST_WALK;
					M_REHASH: state_d = ri_last ? ST_HASH : ST_RH_RD;
					default:  state_d = ST_DONE;
				endcase
			end
			ST_WALK:  state_d = cur_ok ? ST_CMP : ST_DECIDE;
			ST_CMP:   state_d = key_hit ? ST_DECIDE : ST_WALK;
			ST_DECIDE: begin
				priority if (func_q == FN_REMOVE && found_q) begin
					state_d = ST_REMOVE;
				end else if (func_q == FN_ADD && !found_q &&
				             used_q < LW'(MAX_ENTRIES)) begin
					state_d = grow ? ST_SWEEP : ST_HASH;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_RH_RD:  state_d = ST_RH_CHK;
			ST_RH_CHK: begin
				if (!rm_rd_q) begin
					state_d = ST_HASH;
				end else begin
					state_d = ri_last ? ST_HASH : ST_RH_RD;
				end
			end
			ST_REMOVE: state_d = ST_DONE;
			ST_DONE: begin
				if (done_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory controls
	always_comb begin
		head_we = 1'b0;
		head_wa = h_q;
		head_wd = NIL;
		key_we  = 1'b0;
		key_wa  = used_q[AW-1:0];
		key_wd  = item_q;
		link_we = 1'b0;
		link_wa = used_q[AW-1:0];
		link_wd = head_rd_q;
		rm_we   = 1'b0;
		rm_wa   = used_q[AW-1:0];
		rm_wd   = 1'b0;
		head_ra = bucket;
		key_ra  = (state_q == ST_RH_RD) ? ri_q[AW-1:0] : cur_q[AW-1:0];
		unique case (state_q)
			ST_SWEEP: begin
				head_we = 1'b1;
				head_wa = sw_q;
			end
			ST_HEADW: begin
				if (mode_q == M_REHASH) begin
					head_we = 1'b1;
					head_wd = ri_q;
					link_we = 1'b1;
					link_wa = ri_q[AW-1:0];
				end else if (mode_q == M_INSERT) begin
					head_we = 1'b1;
					head_wd = used_q;
					link_we = 1'b1;
					key_we  = 1'b1;
					rm_we   = 1'b1;
				end
			end
			ST_REMOVE: begin
				rm_we = 1'b1;
				rm_wa = slot_q[AW-1:0];
				rm_wd = 1'b1;
				if (prev_q == NIL) begin
					head_we = 1'b1;
					head_wd = next_q;
				end else begin
					link_we = 1'b1;
					link_wa = prev_q[AW-1:0];
					link_wd = next_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_wa] <= head_wd;
		end
		head_rd_q <= head_mem[head_ra];
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_wa] <= key_wd;
		end
		key_rd_q <= key_mem[key_ra];
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		link_rd_q <= link_mem[key_ra];
	end

	always_ff @(posedge clk) begin
		if (rm_we) begin
			rm_mem[rm_wa] <= rm_wd;
		end
		rm_rd_q <= rm_mem[key_ra];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			mode_q      <= M_INIT;
			size_q      <= RESET_SIZE_LOG2;
			used_q      <= '0;
			removed_q   <= '0;
			ri_q        <= '0;
			sw_q        <= '0;
			hcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (done_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			// Advance the sweep index; restart it whenever a sweep begins.
			if (state_q == ST_SWEEP) begin
				sw_q <= HEAD_AW'(sw_q + 1'b1);
			end else begin
				sw_q <= '0;
			end
			if (state_q == ST_HASH) begin
				hcnt_q <= 2'(hcnt_q + 1'b1);
			end else begin
				hcnt_q <= '0;
			end
			if (cfg_acc) begin
				// Configuration write: empty the set and sweep the new head range.
				size_q    <= (cfg_data > SIZE_W'(HEAD_LOG2_MAX)) ?
				             SIZE_W'(HEAD_LOG2_MAX) : cfg_data;
				used_q    <= '0;
				removed_q <= '0;
				mode_q    <= M_INIT;
			end else begin
				unique case (state_q)
					ST_SWEEP: begin
						if (sw_q == sw_last && mode_q == M_REHASH) begin
							ri_q <= '0;
							if (used_q == '0) begin
								mode_q <= M_INSERT;
							end
						end
					end
					ST_IDLE: begin
						if (in_acc) begin
							if (func_t'(func) == FN_CLEAR) begin
								mode_q    <= M_CLEAR;
								used_q    <= '0;
								removed_q <= '0;
							end else begin
								mode_q <= M_LOOKUP;
							end
						end
					end
					ST_HEADW: begin
						if (mode_q == M_REHASH) begin
							ri_q <= LW'(ri_q + 1'b1);
							if (ri_last) begin
								mode_q <= M_INSERT;
							end
						end else if (mode_q == M_INSERT) begin
							used_q <= LW'(used_q + 1'b1);
						end
					end
					ST_DECIDE: begin
						if (func_q == FN_ADD && !found_q &&
						    used_q < LW'(MAX_ENTRIES)) begin
							if (grow) begin
								size_q <= SIZE_W'(size_q + 1'b1);
								mode_q <= M_REHASH;
							end else begin
								mode_q <= M_INSERT;
							end
						end
					end
					ST_RH_CHK: begin
						if (rm_rd_q) begin
							ri_q <= LW'(ri_q + 1'b1);
							if (ri_last) begin
								mode_q <= M_INSERT;
							end
						end
					end
					ST_REMOVE: begin
						removed_q <= LW'(removed_q + 1'b1);
					end
					default: ;
				endcase
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					func_q  <= func_t'(func);
					item_q  <= {key_c[KEY_WIDTH-1:0], key_b[KEY_WIDTH-1:0],
					            key_a[KEY_WIDTH-1:0]};
					op_a_q  <= key_a[KEY_WIDTH-1:0];
					op_b_q  <= key_b[KEY_WIDTH-1:0];
					op_c_q  <= key_c[KEY_WIDTH-1:0];
					found_q <= 1'b0;
					full_q  <= 1'b0;
				end
			end
			ST_HASH: begin
				prod_q <= 32'(mul_op) * mul_k;
				acc_q  <= (hcnt_q == 2'd0) ? '0 : acc_q + prod_q;
			end
			ST_HEAD: h_q <= bucket;
			ST_HEADW: begin
				cur_q  <= head_rd_q;
				prev_q <= NIL;
			end
			ST_CMP: begin
				if (key_hit) begin
					found_q <= 1'b1;
					slot_q  <= cur_q;
					next_q  <= link_rd_q;
				end else begin
					prev_q <= cur_q;
					cur_q  <= link_rd_q;
				end
			end
			ST_DECIDE: begin
				if (func_q == FN_ADD && !found_q && used_q >= LW'(MAX_ENTRIES)) begin
					full_q <= 1'b1;
				end
			end
			ST_RH_CHK: begin
				if (!rm_rd_q) begin
					op_a_q <= key_rd_q[KEY_WIDTH-1:0];
					op_b_q <= key_rd_q[2*KEY_WIDTH-1:KEY_WIDTH];
					op_c_q <= key_rd_q[KW3-1:2*KEY_WIDTH];
				end
			end
			ST_DONE: begin
				if (done_load) begin
					found_out_q <= found_q;
					full_out_q  <= full_q;
					live_out_q  <= live32[LIVE_W-1:0];
				end
			end
			default: ;
		endcase
		// Reload the item's key for the final insert hash.
		if ((state_q == ST_DECIDE && state_d == ST_HASH) ||
		    (state_q == ST_SWEEP && state_d == ST_HASH) ||
		    (state_q == ST_HEADW && mode_q == M_REHASH && ri_last) ||
		    (state_q == ST_RH_CHK && rm_rd_q && ri_last)) begin
			op_a_q <= item_q[KEY_WIDTH-1:0];
			op_b_q <= item_q[2*KEY_WIDTH-1:KEY_WIDTH];
			op_c_q <= item_q[KW3-1:2*KEY_WIDTH];
		end
	end

endmodule

FILE: sim/chained_hash_set_triples_top_test.sv
`timescale 1ns / 1ps
// Testbench for the chained hash set of key triples: random and directed
// operations checked against an in-bench set model. Depends on chs_pkg and the top.

// Scoreboard: hold the expected result of each accepted operation and
// compare the block's results in order.
class set_scoreboard;
	typedef struct packed {
		logic       found;
		logic       pool_full;
		logic [10:0] live;
	} result_t;

	// mirror of the set
	int unsigned heads[2048];
	logic [31:0] ka[1024], kb[1024], kc[1024];
	int unsigned link[1024];
	bit gone[1024];
	int unsigned used, removed, lg;
	result_t pending[$];
	int mismatches;
	int results_seen;
	int hits, fulls, grows;

	function void empty_all();
		foreach (heads[i]) heads[i] = 1024;
		foreach (gone[i]) gone[i] = 0;
		used = 0;
		removed = 0;
	endfunction

	function void set_size(logic [3:0] v);
		lg = (v > 11) ? 11 : v;
		empty_all();
	endfunction

	function int unsigned bucket(logic [31:0] a, logic [31:0] b, logic [31:0] c);
		logic [31:0] s;
		s = a * 32'd159403 + b * 32'd389651 + c * 32'd521503;
		return s & ((32'd1 << lg) - 1);
	endfunction

	function void grow();
		int unsigned h;
		if (4 * (used - removed) < 3 * (1 << lg) || lg >= 11) return;
		lg++;
		grows++;
		for (int i = 0; i < (1 << lg); i++) heads[i] = 1024;
		for (int i = 0; i < used; i++) if (!gone[i]) begin
			h = bucket(ka[i], kb[i], kc[i]);
			link[i] = heads[h];
			heads[h] = i;
		end
	endfunction

	// note an accepted operation: apply it and queue the expected result
	function void note_op(chs_pkg::func_t f, logic [31:0] a, logic [31:0] b,
			logic [31:0] c);
		result_t r;
		int unsigned h, i, p, hit, n;
		r = '0;
		if (f == chs_pkg::FN_CLEAR) begin
			empty_all();
		end else begin
			h = bucket(a, b, c);
			i = heads[h];
			p = 1024;
			hit = 1024;
			n = 0;
			while (i < 1024 && i < used && n < 1024) begin
				if (ka[i] == a && kb[i] == b && kc[i] == c) begin
					hit = i;
					break;
				end
				p = i;
				i = link[i];
				n++;
			end
			r.found = (hit != 1024);
			if (r.found) hits++;
			if (f == chs_pkg::FN_ADD && !r.found) begin
				if (used >= 1024) begin
					r.pool_full = 1;
					fulls++;
				end else begin
					grow();
					h = bucket(a, b, c);
					ka[used] = a;
					kb[used] = b;
					kc[used] = c;
					gone[used] = 0;
					link[used] = heads[h];
					heads[h] = used;
					used++;
				end
			end else if (f == chs_pkg::FN_REMOVE && r.found) begin
				if (p == 1024) heads[h] = link[hit];
				else link[p] = link[hit];
				gone[hit] = 1;
				removed++;
			end
		end
		r.live = (used - removed) & 11'h7FF;
		pending = {pending, r};
	endfunction

	function void check(logic fnd, logic full, logic [10:0] live);
		result_t e;
		results_seen++;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result word %b %b %0d", fnd, full, live);
			return;
		end
		e = pending.pop_front();
		if (e.found !== fnd || e.pool_full !== full || e.live !== live) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected found=%b full=%b live=%0d, got %b %b %0d",
					e.found, e.pool_full, e.live, fnd, full, live);
		end
	endfunction
endclass

module chained_hash_set_triples_top_test;
	import chs_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [SIZE_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic [FUNC_W-1:0] func = '0;
	logic [31:0] key_a = '0, key_b = '0, key_c = '0;
	logic out_valid;
	logic out_ready = 0;
	logic found, pool_full;
	logic [LIVE_W-1:0] live_count;

	set_scoreboard sb;
	int unsigned cycles = 0;
	int hold_off = 0;   // long receiver stall, counted down in its own process
	bit done_in = 0;
	int cfg_writes = 0;

	// pool of recent triples so that finds and removes hit
	logic [31:0] recent_a[64], recent_b[64], recent_c[64];
	int recent_n = 0;

	chained_hash_set_triples_top uut (.*);

	always #5 clk = ~clk;

	// watchdog: generous bound, covers full-pool rehashes and long stalls
	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("[chained_hash_set_triples_top] ERROR");
			$finish;
		end
	end

	// sample accepted results at the rising edge
	always @(posedge clk)
		if (arst_n && out_valid && out_ready) sb.check(found, pool_full, live_count);

	// receiver: random stalls, mostly short; honor any long hold-off
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 0;
		end else if (done_in) out_ready <= 1;
		else out_ready <= ($urandom_range(0, 9) < 7);
	end

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// send one operation word; hold valid until it is accepted
	task send(func_t f, logic [31:0] a, logic [31:0] b, logic [31:0] c);
		int g;
		g = gap_len();
		repeat (g + 1) @(negedge clk);
		in_valid <= 1;
		func <= f;
		key_a <= a;
		key_b <= b;
		key_c <= c;
		do @(posedge clk); while (!in_ready);
		sb.note_op(f, a, b, c);
		if (f == FN_ADD) begin
			recent_a[recent_n % 64] = a;
			recent_b[recent_n % 64] = b;
			recent_c[recent_n % 64] = c;
			recent_n++;
		end
		@(negedge clk);
		in_valid <= 0;
	endtask

	// drain every result, let the block settle, then write the register
	task write_size(logic [3:0] v);
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_size(v);
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task random_op(int hit_pct, int unsigned narrow);
		int r, k;
		logic [31:0] a, b, c;
		r = $urandom_range(0, 99);
		if (recent_n > 0 && $urandom_range(0, 99) < hit_pct) begin
			k = $urandom_range(0, (recent_n < 64 ? recent_n : 64) - 1);
			a = recent_a[k];
			b = recent_b[k];
			c = recent_c[k];
		end else begin
			a = $urandom & narrow;
			b = $urandom & narrow;
			c = $urandom & narrow;
		end
		if (r < 45) send(FN_ADD, a, b, c);
		else if (r < 70) send(FN_FIND, a, b, c);
		else if (r < 98) send(FN_REMOVE, a, b, c);
		else send(FN_CLEAR, a, b, c);
	endtask

	initial begin
		sb = new();
		sb.set_size(RESET_SIZE_LOG2);
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed: field extremes and each operation
		send(FN_FIND, 32'h0, 32'h0, 32'h0);
		send(FN_ADD, 32'h0, 32'h0, 32'h0);
		send(FN_ADD, 32'h0, 32'h0, 32'h0);          // already present
		send(FN_ADD, '1, '1, '1);
		send(FN_FIND, '1, '1, '1);
		send(FN_ADD, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1);
		send(FN_REMOVE, 32'h1234, 32'h5, 32'h6);     // absent
		send(FN_REMOVE, '1, '1, '1);
		send(FN_FIND, '1, '1, '1);
		send(FN_ADD, '1, '1, '1);                    // removed slot is not reused
		for (int i = 0; i < 12; i++) send(FN_ADD, i, 32'hFFFF_0000 ^ i, 32'h8000_0000 | i);
		send(FN_CLEAR, 32'h0, 32'h0, 32'h0);
		send(FN_FIND, 32'h0, 32'h0, 32'h0);

		// smallest table and oversized register value
		write_size(4'd0);
		for (int i = 0; i < 40; i++) random_op(40, 32'h0000_00FF);
		write_size(4'd15);
		for (int i = 0; i < 30; i++) random_op(40, 32'hFFFF_FFFF);

		// long receiver stall while the sender keeps offering words
		write_size(4'd2);
		hold_off = 300;
		for (int i = 0; i < 20; i++) send(FN_ADD, $urandom, $urandom, $urandom);

		// fill the pool past its size to hit the full case and deep rehashes
		write_size(4'd1);
		for (int i = 0; i < 1040; i++) send(FN_ADD, i * 7 + 3, $urandom, i);
		send(FN_FIND, 32'd3, 32'd0, 32'd0);
		send(FN_REMOVE, recent_a[0], recent_b[0], recent_c[0]);
		send(FN_ADD, 32'h77, 32'h77, 32'h77);       // still full: slot not reused

		// random mix at several sizes, often hitting earlier triples
		write_size(4'd11);
		for (int i = 0; i < 150; i++) random_op(60, 32'hFFFF_FFFF);
		write_size(4'd4);
		for (int i = 0; i < 250; i++) random_op(60, 32'hFFFF_FFFF);
		write_size(4'd7);
		for (int i = 0; i < 100; i++) random_op(30, 32'h0000_000F);

		done_in = 1;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		$display("covered %0d results, %0d hits, %0d full-pool drops, %0d table doublings,",
			sb.results_seen, sb.hits, sb.fulls, sb.grows);
		$display("%0d size writes, %0d mismatches", cfg_writes, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("[chained_hash_set_triples_top] OK");
		else
			$display("[chained_hash_set_triples_top] ERROR");
		$finish;
	end
endmodule

FILE: chained_hash_set_triples_top.f
rtl/chs_pkg.sv
rtl/chained_hash_set_triples_top.sv
sim/chained_hash_set_triples_top_test.sv
